// ===== rtl/ghe_pkg.sv =====
// Package for the grayscale histogram engine.
// Holds sizes, item mode codes, controller states and the command/status structs.
// No dependencies.
package ghe_pkg;

  localparam int BINS       = 256;
  localparam int COUNT_BITS = 21;
  localparam int BIN_W      = (BINS > 1) ? $clog2(BINS) : 1;
  localparam int PIX_W      = 8;
  localparam int MODE_W     = 2;
  localparam int OUT_W      = 21;

  localparam logic [COUNT_BITS-1:0] COUNT_MAX = {COUNT_BITS{1'b1}};

  typedef enum logic [MODE_W-1:0] {
    MODE_CLEAR = 2'd0,
    MODE_COUNT = 2'd1,
    MODE_READ  = 2'd2
  } mode_t;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_COUNT,
    ST_READ
  } state_t;

  typedef struct packed {
    logic load;
    logic sel_bin;
    logic clear;
    logic write;
    logic emit;
  } cmd_t;

  typedef struct packed {
    logic out_full;
  } sts_t;

endpackage

// ===== rtl/ghe_ctrl.sv =====
// Controller of the grayscale histogram engine.
// Sequences clear, count (read-modify-write) and read transactions; uses ghe_pkg.
module ghe_ctrl (
  input  logic                      clk,
  input  logic                      rst_n,
  input  logic                      in_valid,
  input  logic [ghe_pkg::MODE_W-1:0] in_mode,
  output logic                      in_ready,
  input  ghe_pkg::sts_t             sts,
  output ghe_pkg::cmd_t             cmd
);

  ghe_pkg::state_t state_r, state_nxt;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ghe_pkg::ST_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

  always_comb begin
    state_nxt   = state_r;
    in_ready    = 1'b0;
    cmd         = '0;
    case (state_r)
      ghe_pkg::ST_IDLE: begin
        in_ready = 1'b1;
        if (in_valid) begin
          case (in_mode)
            ghe_pkg::MODE_CLEAR: begin
              cmd.clear = 1'b1;
            end
            ghe_pkg::MODE_COUNT: begin
              cmd.load  = 1'b1;
              state_nxt = ghe_pkg::ST_COUNT;
            end
            ghe_pkg::MODE_READ: begin
              cmd.load    = 1'b1;
              cmd.sel_bin = 1'b1;
              state_nxt   = ghe_pkg::ST_READ;
            end
            default: begin
              state_nxt = ghe_pkg::ST_IDLE;
            end
          endcase
        end
      end
      ghe_pkg::ST_COUNT: begin
        cmd.write = 1'b1;
        state_nxt = ghe_pkg::ST_IDLE;
      end
      ghe_pkg::ST_READ: begin
        if (!sts.out_full) begin
          cmd.emit  = 1'b1;
          state_nxt = ghe_pkg::ST_IDLE;
        end
      end
      default: begin
        state_nxt = ghe_pkg::ST_IDLE;
      end
    endcase
  end

endmodule

// ===== rtl/ghe_datapath.sv =====
// Datapath of the grayscale histogram engine: bin memory, valid bits,
// saturating increment and output register. Uses ghe_pkg.
module ghe_datapath (
  input  logic                          clk,
  input  logic                          rst_n,
  input  ghe_pkg::cmd_t                 cmd,
  output ghe_pkg::sts_t                 sts,
  input  logic [ghe_pkg::PIX_W-1:0]     in_pixel,
  input  logic [ghe_pkg::PIX_W-1:0]     in_bin,
  output logic                          out_valid,
  input  logic                          out_ready,
  output logic [ghe_pkg::OUT_W-1:0]     out_count
);

  logic [ghe_pkg::COUNT_BITS-1:0] mem [ghe_pkg::BINS];
  logic [ghe_pkg::BINS-1:0]       valid_r;

  logic [ghe_pkg::PIX_W-1:0]      sel_addr;
  logic                           sel_in_range;
  logic [ghe_pkg::BIN_W-1:0]      addr_r;
  logic                           in_range_r;
  logic [ghe_pkg::COUNT_BITS-1:0] rd_data_r;
  logic                           rd_vld_r;
  logic [ghe_pkg::COUNT_BITS-1:0] cur;
  logic                           out_valid_r;
  logic [ghe_pkg::OUT_W-1:0]      out_count_r;
  logic [ghe_pkg::OUT_W-1:0]      cur_out;

  assign sel_addr     = cmd.sel_bin ? in_bin : in_pixel;
  assign sel_in_range = (32'(sel_addr) < ghe_pkg::BINS);
  assign cur          = rd_vld_r ? rd_data_r : '0;
  assign cur_out      = ghe_pkg::OUT_W'(cur);

  always_ff @(posedge clk) begin
    if (cmd.load) begin
      addr_r     <= sel_addr[ghe_pkg::BIN_W-1:0];
      in_range_r <= sel_in_range;
      rd_data_r  <= mem[sel_addr[ghe_pkg::BIN_W-1:0]];
      rd_vld_r   <= valid_r[sel_addr[ghe_pkg::BIN_W-1:0]];
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.write && in_range_r && (cur != ghe_pkg::COUNT_MAX)) begin
      mem[addr_r] <= cur + 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= '0;
    end else if (cmd.clear) begin
      valid_r <= '0;
    end else if (cmd.write && in_range_r && (cur != ghe_pkg::COUNT_MAX)) begin
      valid_r[addr_r] <= 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (cmd.emit) begin
      out_valid_r <= 1'b1;
    end else if (out_ready) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.emit) begin
      out_count_r <= in_range_r ? cur_out : '0;
    end
  end

  assign sts.out_full = out_valid_r && !out_ready;
  assign out_valid    = out_valid_r;
  assign out_count    = out_count_r;

`ifndef SYNTHESIS
  a_clear_empties: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.clear |=> (valid_r == '0))
    else $error("valid bits not cleared");
  a_emit_shows: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.emit |=> out_valid_r)
    else $error("emitted result not presented");
  a_emit_no_overwrite: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.emit |-> !(out_valid_r && !out_ready))
    else $error("result overwritten while held");
  a_cmd_exclusive: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.write |-> (!cmd.load && !cmd.clear && !cmd.emit))
    else $error("write overlaps another command");
`endif

endmodule

// ===== rtl/gray_histogram_engine_top.sv =====
// Top level of the grayscale histogram engine: 256 saturating 21-bit bins.
// Instantiates ghe_ctrl and ghe_datapath; uses ghe_pkg.
//
// Each input transaction carries a mode. Clear zeroes all bins together
// (per-bin valid bits) and returns nothing. Count adds one to the bin of the
// pixel, saturating at 2^21-1, and returns nothing. Read returns one result
// with the count of the named bin. Mode 3 is dropped. Count and read first
// do a registered read of the bin memory, then the write-back or the load of
// the output register. A read waits before loading the output register while
// that register still holds an untaken result; the input side is not blocked
// by a waiting result otherwise. No clearing pass after reset.
module gray_histogram_engine_top (
  input  logic                        clk,
  input  logic                        rst_n,
  input  logic                        in_valid,
  output logic                        in_ready,
  input  logic [ghe_pkg::MODE_W-1:0]  in_mode,
  input  logic [ghe_pkg::PIX_W-1:0]   in_pixel,
  input  logic [ghe_pkg::PIX_W-1:0]   in_bin,
  output logic                        out_valid,
  input  logic                        out_ready,
  output logic [ghe_pkg::OUT_W-1:0]   out_count
);

  ghe_pkg::cmd_t cmd;
  ghe_pkg::sts_t sts;

  ghe_ctrl u_ctrl (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_valid),
    .in_mode  (in_mode),
    .in_ready (in_ready),
    .sts      (sts),
    .cmd      (cmd)
  );

  ghe_datapath u_datapath (
    .clk       (clk),
    .rst_n     (rst_n),
    .cmd       (cmd),
    .sts       (sts),
    .in_pixel  (in_pixel),
    .in_bin    (in_bin),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .out_count (out_count)
  );

endmodule

// ===== bench/tb.sv =====
// Testbench for gray_histogram_engine_top: directed table, then random image passes.
// A local bin-count predictor, or the count typed in a directed row, checks every
// read result. Depends on ghe_pkg and the RTL top level.
`timescale 1ns / 1ps

module tb;

  localparam logic [ghe_pkg::MODE_W-1:0] MODE_UNUSED = 2'd3;
  localparam int CYCLE_LIMIT = 200_000;
  localparam int HOLD_CYCLES = 300;

  typedef struct {
    logic [ghe_pkg::MODE_W-1:0] mode;
    logic [ghe_pkg::PIX_W-1:0]  pixel;
    logic [ghe_pkg::PIX_W-1:0]  bin;
    bit                         typed;
    logic [ghe_pkg::OUT_W-1:0]  count;
  } row_t;

  logic                         clk = 1'b0;
  logic                         rst_n = 1'b0;
  logic                         in_valid = 1'b0;
  logic                         in_ready;
  logic [ghe_pkg::MODE_W-1:0]   in_mode = ghe_pkg::MODE_CLEAR;
  logic [ghe_pkg::PIX_W-1:0]    in_pixel = '0;
  logic [ghe_pkg::PIX_W-1:0]    in_bin = '0;
  logic                         out_valid;
  logic                         out_ready = 1'b0;
  logic [ghe_pkg::OUT_W-1:0]    out_count;

  logic [ghe_pkg::COUNT_BITS-1:0] bin_hist [ghe_pkg::BINS];
  logic [ghe_pkg::OUT_W-1:0]      count_expect_q [$];
  bit                             row_typed = 1'b0;
  logic [ghe_pkg::OUT_W-1:0]      row_count = '0;

  int  snd_idle_pct = 0;
  int  rcv_idle_pct = 0;
  bit  holding = 1'b0;
  event hold_ev;
  int  errors = 0;
  int  items_sent = 0;
  int  reads_checked = 0;
  int  cycle_count = 0;

  gray_histogram_engine_top u_top (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .in_mode   (in_mode),
    .in_pixel  (in_pixel),
    .in_bin    (in_bin),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .out_count (out_count)
  );

  always #5 clk = ~clk;

  always @(posedge clk) begin
    cycle_count++;
    if (cycle_count > CYCLE_LIMIT) begin
      $display("tb: FAIL");
      $finish;
    end
  end

  function automatic void hist_apply(logic [ghe_pkg::MODE_W-1:0] mode,
                                     logic [ghe_pkg::PIX_W-1:0] pixel,
                                     logic [ghe_pkg::PIX_W-1:0] bin, bit typed,
                                     logic [ghe_pkg::OUT_W-1:0] typed_count);
    case (mode)
      ghe_pkg::MODE_CLEAR: begin
        foreach (bin_hist[i]) bin_hist[i] = '0;
      end
      ghe_pkg::MODE_COUNT: begin
        if (bin_hist[pixel] != ghe_pkg::COUNT_MAX) bin_hist[pixel] = bin_hist[pixel] + 1'b1;
      end
      ghe_pkg::MODE_READ: begin
        count_expect_q.push_back(typed ? typed_count : bin_hist[bin][ghe_pkg::OUT_W-1:0]);
      end
      default: ;
    endcase
  endfunction

  always @(posedge clk) begin
    logic [ghe_pkg::OUT_W-1:0] want;
    if (rst_n) begin
      if (out_valid && out_ready) begin
        if (count_expect_q.size() == 0) begin
          $error("unexpected result: count actual %0d", out_count);
          errors++;
        end else begin
          want = count_expect_q.pop_front();
          reads_checked++;
          if (out_count !== want) begin
            $error("count mismatch: expected %0d, actual %0d", want, out_count);
            errors++;
          end
        end
      end
      if (in_valid && in_ready) hist_apply(in_mode, in_pixel, in_bin, row_typed, row_count);
    end
  end

  always @(negedge clk) begin
    if (holding) begin
      out_ready <= 1'b0;
    end else begin
      out_ready <= ($urandom_range(99) >= rcv_idle_pct);
    end
  end

  always begin
    @(hold_ev);
    holding = 1'b1;
    repeat (HOLD_CYCLES) @(negedge clk);
    holding = 1'b0;
  end

  // call at a falling edge; returns at the falling edge after acceptance
  task automatic send_item(input logic [ghe_pkg::MODE_W-1:0] mode,
                           input logic [ghe_pkg::PIX_W-1:0] pixel,
                           input logic [ghe_pkg::PIX_W-1:0] bin, input bit typed = 1'b0,
                           input logic [ghe_pkg::OUT_W-1:0] typed_count = '0);
    while ($urandom_range(99) < snd_idle_pct) begin
      in_valid <= 1'b0;
      @(negedge clk);
    end
    in_valid  <= 1'b1;
    in_mode   <= mode;
    in_pixel  <= pixel;
    in_bin    <= bin;
    row_typed = typed;
    row_count = typed_count;
    @(posedge clk);
    while (!in_ready) @(posedge clk);
    @(negedge clk);
    if (mode != MODE_UNUSED) items_sent++;
  endtask

  // one image: clear, a run of pixels, then reads; sometimes broken or pure noise
  task automatic run_image();
    int n_pix;
    int n_rd;
    int spread;
    logic [ghe_pkg::PIX_W-1:0] base;
    logic [ghe_pkg::PIX_W-1:0] pick;
    base = 8'($urandom);
    spread = ($urandom_range(1) == 0) ? 7 : 255;
    if ($urandom_range(99) < 15) begin
      repeat ($urandom_range(20, 5)) begin
        pick = 8'($urandom_range(3));
        if (pick == ghe_pkg::MODE_CLEAR && $urandom_range(3) != 0) pick = ghe_pkg::MODE_READ;
        send_item(pick[ghe_pkg::MODE_W-1:0], 8'($urandom), 8'($urandom));
      end
    end else begin
      if ($urandom_range(9) != 0) send_item(ghe_pkg::MODE_CLEAR, 8'($urandom), 8'($urandom));
      n_pix = $urandom_range(60, 10);
      repeat (n_pix) begin
        if ($urandom_range(99) < 4) send_item(MODE_UNUSED, 8'($urandom), 8'($urandom));
        if ($urandom_range(99) < 6)
          send_item(ghe_pkg::MODE_READ, 8'($urandom), 8'(base + $urandom_range(spread)));
        send_item(ghe_pkg::MODE_COUNT, 8'(base + $urandom_range(spread)), 8'($urandom));
      end
      n_rd = $urandom_range(15, 4);
      repeat (n_rd) begin
        pick = ($urandom_range(3) == 0) ? 8'($urandom) : 8'(base + $urandom_range(spread));
        send_item(ghe_pkg::MODE_READ, 8'($urandom), pick);
      end
    end
  endtask

  row_t directed [] = '{
    '{ghe_pkg::MODE_READ,  8'h00, 8'h00, 1'b1, 21'd0},
    '{ghe_pkg::MODE_READ,  8'hFF, 8'hFF, 1'b1, 21'd0},
    '{ghe_pkg::MODE_COUNT, 8'h00, 8'hFF, 1'b0, 21'd0},
    '{ghe_pkg::MODE_COUNT, 8'h00, 8'h00, 1'b0, 21'd0},
    '{ghe_pkg::MODE_COUNT, 8'hFF, 8'h00, 1'b0, 21'd0},
    '{ghe_pkg::MODE_READ,  8'hFF, 8'h00, 1'b1, 21'd2},
    '{ghe_pkg::MODE_READ,  8'h00, 8'hFF, 1'b1, 21'd1},
    '{ghe_pkg::MODE_COUNT, 8'hAA, 8'h55, 1'b0, 21'd0},
    '{ghe_pkg::MODE_COUNT, 8'h55, 8'hAA, 1'b0, 21'd0},
    '{ghe_pkg::MODE_READ,  8'h55, 8'hAA, 1'b0, 21'd0},
    '{ghe_pkg::MODE_READ,  8'hAA, 8'h55, 1'b0, 21'd0},
    '{MODE_UNUSED,         8'h55, 8'h55, 1'b0, 21'd0},
    '{ghe_pkg::MODE_READ,  8'h00, 8'h55, 1'b0, 21'd0},
    '{ghe_pkg::MODE_COUNT, 8'h55, 8'h00, 1'b0, 21'd0},
    '{ghe_pkg::MODE_READ,  8'h00, 8'h55, 1'b0, 21'd0},
    '{ghe_pkg::MODE_READ,  8'h00, 8'h55, 1'b0, 21'd0},
    '{ghe_pkg::MODE_CLEAR, 8'hFF, 8'hFF, 1'b0, 21'd0},
    '{ghe_pkg::MODE_READ,  8'h00, 8'h00, 1'b1, 21'd0},
    '{ghe_pkg::MODE_READ,  8'h00, 8'h55, 1'b1, 21'd0},
    '{ghe_pkg::MODE_READ,  8'h00, 8'hFF, 1'b1, 21'd0},
    '{ghe_pkg::MODE_COUNT, 8'h7F, 8'h80, 1'b0, 21'd0},
    '{ghe_pkg::MODE_COUNT, 8'h80, 8'h7F, 1'b0, 21'd0},
    '{ghe_pkg::MODE_READ,  8'h00, 8'h80, 1'b0, 21'd0},
    '{ghe_pkg::MODE_READ,  8'h00, 8'h7F, 1'b0, 21'd0}
  };

  initial begin
    bit hold_done;
    foreach (bin_hist[i]) bin_hist[i] = '0;
    hold_done = 1'b0;
    snd_idle_pct = 36;
    rcv_idle_pct = 57;
    repeat (5) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;
    @(negedge clk);

    foreach (directed[i])
      send_item(directed[i].mode, directed[i].pixel, directed[i].bin,
                directed[i].typed, directed[i].count);

    while (items_sent < 325) begin
      if (!hold_done && items_sent > 150) begin
        ->hold_ev;
        hold_done = 1'b1;
      end
      run_image();
    end
    snd_idle_pct = 57;
    rcv_idle_pct = 36;
    while (items_sent < 625) run_image();
    snd_idle_pct = 0;
    rcv_idle_pct = 0;
    while (items_sent < 925) run_image();
    in_valid <= 1'b0;

    while (count_expect_q.size() != 0) @(posedge clk);
    repeat (10) @(posedge clk);

    $display("tb: %0d transactions accepted, %0d read results checked", items_sent,
             reads_checked);
    $display("tb: all modes, unused mode and output hold-off under load covered");
    if (errors == 0) begin
      $display("tb: PASS");
    end else begin
      $display("tb: FAIL");
    end
    $finish;
  end

endmodule

// ===== files.f =====
rtl/ghe_pkg.sv
rtl/ghe_ctrl.sv
rtl/ghe_datapath.sv
rtl/gray_histogram_engine_top.sv
bench/tb.sv
